[hdl/hld_pkg.sv]
// Package: shared types, codes and constants of the lamp dimmer.
`default_nettype none

package hld_pkg;

  localparam int LEVEL_W = 10;
  localparam int DUTY_W  = 8;
  localparam int COND_W  = 3;
  localparam int CODE_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;
  localparam int PROD_W  = LEVEL_W + DUTY_W;
  localparam int QUOT_W  = DUTY_W;
  localparam int STEP_W  = $clog2(QUOT_W);

  localparam logic [LEVEL_W-1:0] LEVEL_LIMIT = LEVEL_W'(1000);

  localparam logic [LEVEL_W-1:0] ON_TH_RESET  = LEVEL_W'(200);
  localparam logic [LEVEL_W-1:0] OFF_TH_RESET = LEVEL_W'(300);
  localparam logic [DUTY_W-1:0]  MIN_DUTY_RESET = DUTY_W'(1);
  localparam logic [DUTY_W-1:0]  MAX_DUTY_RESET = DUTY_W'(255);

  localparam logic [COND_W-1:0] COND_VALID = COND_W'(0);
  localparam logic [COND_W-1:0] COND_ABOVE = COND_W'(1);

  localparam logic CMD_INIT   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [CODE_W-1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_FAULT = 2'd2
  } mode_t;

  typedef enum logic [CODE_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_HWFAIL  = 2'd2,
    STAT_NOINIT  = 2'd3
  } status_t;

  typedef enum logic [CODE_W-1:0] {
    DIAG_READY  = 2'd0,
    DIAG_ACTIVE = 2'd1,
    DIAG_FAULT  = 2'd2
  } diag_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ON_TH    = 2'd0,
    REG_OFF_TH   = 2'd1,
    REG_MIN_DUTY = 2'd2,
    REG_MAX_DUTY = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MULT,
    ST_DIV,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

[hdl/hld_if.sv]
// Interfaces: sample input channel and result output channel.
`default_nettype none

interface hld_in_if import hld_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [LEVEL_W-1:0] light_level;
  logic [COND_W-1:0]  sample_condition;

  modport source (output valid, command, light_level, sample_condition, input ready);
  modport sink   (input valid, command, light_level, sample_condition, output ready);
endinterface

interface hld_out_if import hld_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  status_code;
  logic [CODE_W-1:0]  lamp_mode;
  logic [COND_W-1:0]  held_condition;
  logic [CODE_W-1:0]  diagnostic;
  logic [LEVEL_W-1:0] held_light;
  logic [DUTY_W-1:0]  duty_out;
  logic               lamp_lit;

  modport source (output valid, status_code, lamp_mode, held_condition, diagnostic,
                  held_light, duty_out, lamp_lit, input ready);
  modport sink   (input valid, status_code, lamp_mode, held_condition, diagnostic,
                  held_light, duty_out, lamp_lit, output ready);
endinterface

`default_nettype wire

[hdl/hld_divider.sv]
// Restoring divider, one quotient bit per cycle, quotient known to fit QUOT_W bits.
`default_nettype none

module hld_divider import hld_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [LEVEL_W-1:0] divisor,
  output logic                   done,
  output logic [QUOT_W-1:0]      quotient
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [LEVEL_W-1:0] rem;
  logic [QUOT_W-1:0]  quo;
  logic [LEVEL_W:0]   trial;
  logic               fits;
  logic [LEVEL_W-1:0] rem_next;

  // Shift in the next dividend bit and try a subtract.
  always_comb begin
    trial    = {rem, quo[QUOT_W-1]};
    fits     = trial >= {1'b0, divisor};
    rem_next = fits ? LEVEL_W'(trial - {1'b0, divisor}) : trial[LEVEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(QUOT_W - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[PROD_W-1:QUOT_W];
      quo <= dividend[QUOT_W-1:0];
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[QUOT_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

[hdl/hysteresis_lamp_dimmer.sv]
// Top level: lamp controller with hysteresis and dimming over one divider.
//
//  channel   direction  handshake        payload
//  samples   in         valid / ready    command, light_level, sample_condition
//  results   out        valid / ready    status_code, lamp_mode, held_condition,
//                                        diagnostic, held_light, duty_out, lamp_lit
//  cfg       in         cfg_write        cfg_index, cfg_data (no read-back)
//
// An initialize, a fault or a sample that leaves the lamp off passes through the
// evaluate and finish states to the result register. A lamp-on sample also passes
// the multiply and divide states; the divider forms its 8 quotient bits, one per
// cycle. samples.ready is high only in the idle state, entered in the cycle after
// the result loads; a result waiting in the output register does not block
// acceptance, but the next result waits for it to drain. rst is synchronous,
// active high; it restores register defaults and unarms.
`default_nettype none

module hysteresis_lamp_dimmer import hld_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  hld_in_if.sink                     samples,
  hld_out_if.source                  results
);

  // Configuration registers, read live by every transaction.
  logic [LEVEL_W-1:0] on_th;
  logic [LEVEL_W-1:0] off_th;
  logic [DUTY_W-1:0]  min_duty;
  logic [DUTY_W-1:0]  max_duty;

  // Held block state.
  mode_t              mode;
  logic [COND_W-1:0]  cond_hold;
  logic [LEVEL_W-1:0] light_hold;
  logic [DUTY_W-1:0]  duty;
  logic               armed;
  status_t            ret_status;

  // Captured input transaction.
  logic               cmd_q;
  logic [LEVEL_W-1:0] level_q;
  logic [COND_W-1:0]  cond_q;

  logic [PROD_W-1:0]  product;

  state_t state, state_next;

  logic               out_valid;
  status_t            out_status;
  mode_t              out_mode;
  logic [COND_W-1:0]  out_cond;
  diag_t              out_diag;
  logic [LEVEL_W-1:0] out_light;
  logic [DUTY_W-1:0]  out_duty;
  logic               out_lit;

  logic               in_take;
  logic               out_take;
  logic               out_load;
  logic               div_start;
  logic               div_done;
  logic [QUOT_W-1:0]  div_quot;

  logic               cfg_ok;
  mode_t              hyst_mode;
  logic               good_sample;
  logic               need_div;
  logic [LEVEL_W-1:0] bounded;
  logic [LEVEL_W-1:0] dark;
  logic [DUTY_W-1:0]  span;
  diag_t              diag_now;

  assign in_take  = samples.valid && samples.ready;
  assign out_take = results.valid && results.ready;

  // Decision logic for the captured transaction.
  always_comb begin
    cfg_ok = (on_th < off_th) && (off_th <= LEVEL_LIMIT) &&
             (min_duty != '0) && (min_duty <= max_duty);
    good_sample = (cmd_q == CMD_SAMPLE) && armed && (cond_q == COND_VALID) &&
                  (level_q <= LEVEL_LIMIT);
    // Fault drops back to off, then apply the hysteresis band.
    hyst_mode = (mode == MODE_ON) ? MODE_ON : MODE_OFF;
    if (hyst_mode == MODE_OFF && level_q < on_th) begin
      hyst_mode = MODE_ON;
    end else if (hyst_mode == MODE_ON && level_q > off_th) begin
      hyst_mode = MODE_OFF;
    end
    need_div = good_sample && (hyst_mode == MODE_ON);
    bounded  = (level_q < off_th) ? level_q : off_th;
    dark     = off_th - bounded;
    span     = (max_duty >= min_duty) ? DUTY_W'(max_duty - min_duty) : '0;
  end

  always_comb begin
    unique case (mode)
      MODE_ON:    diag_now = DIAG_ACTIVE;
      MODE_FAULT: diag_now = DIAG_FAULT;
      default:    diag_now = DIAG_READY;
    endcase
  end

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_take) state_next = ST_EVAL;
      ST_EVAL:   state_next = need_div ? ST_MULT : ST_FINISH;
      ST_MULT:   state_next = ST_DIV;
      ST_DIV:    if (div_done) state_next = ST_FINISH;
      ST_FINISH: if (!out_valid || out_take) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    samples.ready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE:   samples.ready = 1'b1;
      ST_MULT:   div_start = 1'b1;
      ST_FINISH: out_load = !out_valid || out_take;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      on_th    <= ON_TH_RESET;
      off_th   <= OFF_TH_RESET;
      min_duty <= MIN_DUTY_RESET;
      max_duty <= MAX_DUTY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ON_TH:    on_th    <= cfg_data[LEVEL_W-1:0];
        REG_OFF_TH:   off_th   <= cfg_data[LEVEL_W-1:0];
        REG_MIN_DUTY: min_duty <= cfg_data[DUTY_W-1:0];
        REG_MAX_DUTY: max_duty <= cfg_data[DUTY_W-1:0];
        default:      ;
      endcase
    end
  end

  // Capture the accepted transaction and form the dimming product.
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_q   <= samples.command;
      level_q <= samples.light_level;
      cond_q  <= samples.sample_condition;
    end
    if (state == ST_EVAL) begin
      product <= PROD_W'(span) * PROD_W'(dark);
    end
  end

  // Block state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_OFF;
      cond_hold  <= COND_VALID;
      light_hold <= '0;
      duty       <= '0;
      armed      <= 1'b0;
      ret_status <= STAT_NOINIT;
    end else if (state == ST_EVAL) begin
      priority if (cmd_q == CMD_INIT) begin
        if (cfg_ok) begin
          mode       <= MODE_OFF;
          cond_hold  <= COND_VALID;
          light_hold <= '0;
          duty       <= '0;
          armed      <= 1'b1;
          ret_status <= STAT_OK;
        end else begin
          armed      <= 1'b0;
          ret_status <= STAT_INVALID;
        end
      end else if (!armed) begin
        // Hold everything; report only.
        ret_status <= STAT_NOINIT;
      end else if (cond_q != COND_VALID) begin
        mode       <= MODE_FAULT;
        cond_hold  <= cond_q;
        light_hold <= level_q;
        duty       <= '0;
        ret_status <= STAT_HWFAIL;
      end else if (level_q > LEVEL_LIMIT) begin
        mode       <= MODE_FAULT;
        cond_hold  <= COND_ABOVE;
        light_hold <= level_q;
        duty       <= '0;
        ret_status <= STAT_INVALID;
      end else begin
        mode       <= hyst_mode;
        cond_hold  <= COND_VALID;
        light_hold <= level_q;
        duty       <= '0;
        ret_status <= STAT_OK;
      end
    end else if (state == ST_DIV && div_done) begin
      // A zero off threshold means zero darkness: no scaled part.
      duty <= min_duty + ((off_th != '0) ? div_quot : '0);
    end
  end

  hld_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (off_th),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Output register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= ret_status;
      out_mode   <= mode;
      out_cond   <= cond_hold;
      out_diag   <= diag_now;
      out_light  <= light_hold;
      out_duty   <= duty;
      out_lit    <= (mode == MODE_ON);
    end
  end

  assign results.valid          = out_valid;
  assign results.status_code    = out_status;
  assign results.lamp_mode      = out_mode;
  assign results.held_condition = out_cond;
  assign results.diagnostic     = out_diag;
  assign results.held_light     = out_light;
  assign results.duty_out       = out_duty;
  assign results.lamp_lit       = out_lit;

endmodule

`default_nettype wire

[hdl/hld_checker.sv]
// Checker: port-level assertions on the lamp dimmer, bound to the top level.
`default_nettype none

module hld_checker import hld_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [CODE_W-1:0] lamp_mode,
  input wire logic [CODE_W-1:0] diagnostic,
  input wire logic [DUTY_W-1:0] duty_out,
  input wire logic              lamp_lit
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(duty_out) && $stable(lamp_mode))
    else $error("result changed while stalled");

  // Busy after each accepted transaction.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a transaction");

  a_lit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lamp_lit == (lamp_mode == MODE_ON)))
    else $error("lamp_lit disagrees with mode");

  a_dark_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (lamp_mode != MODE_ON) |-> duty_out == '0)
    else $error("nonzero duty while not on");

  a_diag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((lamp_mode == MODE_ON) == (diagnostic == DIAG_ACTIVE)) &&
                  ((lamp_mode == MODE_FAULT) == (diagnostic == DIAG_FAULT)))
    else $error("diagnostic disagrees with mode");

endmodule

bind hysteresis_lamp_dimmer hld_checker u_hld_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .lamp_mode  (results.lamp_mode),
  .diagnostic (results.diagnostic),
  .duty_out   (results.duty_out),
  .lamp_lit   (results.lamp_lit)
);

`default_nettype wire
